@@ src/wccm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wccm_pkg
// Types, constants and palette functions shared by the waterfall column
// colormap unit.
// ----------------------------------------------------------------------------
package wccm_pkg;

   localparam int MAG_BITS_DEFAULT  = 16;
   localparam int LEVEL_MAX_DEFAULT = 764;

   localparam int GAIN_BITS   = 24;
   localparam int GAIN_FRAC   = 16;
   localparam int LEVEL_BITS  = 10;
   localparam int COLOR_BITS  = 8;
   localparam int COLOR_MAX   = 255;
   localparam int RAMP_TWO    = 510;

   localparam int GAIN_RESET  = 65536;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [1:0] REG_GAIN      = 2'd0;
   localparam logic [1:0] REG_SUM_MODE  = 2'd1;
   localparam logic [1:0] REG_CHAN_A_ON = 2'd2;
   localparam logic [1:0] REG_CHAN_B_ON = 2'd3;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain;
      logic                 sum_mode;
      logic                 chan_a_on;
      logic                 chan_b_on;
   } cfg_type;

   // One word of the queue between the front and back parts.
   typedef struct packed {
      level_type level_a;
      level_type level_b;
      logic      column_end;
   } queue_word_type;

   typedef struct packed {
      logic                      full;
      logic                      empty;
      logic [QUEUE_CNT_BITS-1:0] count;
   } queue_status_type;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } rgb_type;

   function automatic rgb_type first_colour(input level_type v);
      rgb_type c;
      c = '0;
      if (v <= LEVEL_BITS'(COLOR_MAX)) begin
         c.red = v[COLOR_BITS-1:0];
      end else if (v <= LEVEL_BITS'(RAMP_TWO)) begin
         c.red   = COLOR_BITS'(COLOR_MAX);
         c.green = COLOR_BITS'(v - LEVEL_BITS'(COLOR_MAX));
      end else begin
         c.red   = COLOR_BITS'(COLOR_MAX);
         c.green = COLOR_BITS'(COLOR_MAX);
         c.blue  = COLOR_BITS'(v - LEVEL_BITS'(RAMP_TWO));
      end
      return c;
   endfunction

   function automatic rgb_type second_colour(input level_type v);
      rgb_type c;
      c = '0;
      if (v <= LEVEL_BITS'(COLOR_MAX)) begin
         c.green = v[COLOR_BITS-1:0];
      end else if (v <= LEVEL_BITS'(RAMP_TWO)) begin
         c.green = COLOR_BITS'(LEVEL_BITS'(RAMP_TWO) - v);
         c.blue  = COLOR_BITS'(v - LEVEL_BITS'(COLOR_MAX));
      end else begin
         c.red   = COLOR_BITS'(v - LEVEL_BITS'(RAMP_TWO));
         c.green = COLOR_BITS'(v - LEVEL_BITS'(RAMP_TWO));
         c.blue  = COLOR_BITS'(COLOR_MAX);
      end
      return c;
   endfunction

   function automatic color_type sat_add(input color_type a, input color_type b);
      logic [COLOR_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COLOR_BITS] ? COLOR_BITS'(COLOR_MAX) : s[COLOR_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/wccm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wccm_front
// Accepts bin words, scales both magnitudes by the gain in a registered
// multiply stage, saturates the levels and pushes them into the queue.
// ----------------------------------------------------------------------------
module wccm_front
   import wccm_pkg::*;
#(
   parameter int MAG_BITS  = MAG_BITS_DEFAULT,
   parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MAG_BITS-1:0] req_mag_a,
   input  wire logic [MAG_BITS-1:0] req_mag_b,
   input  wire logic                req_column_end,
   input  wire queue_status_type    q_status,
   output logic                     q_push,
   output queue_word_type           q_push_word
);

   localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
   localparam int RAW_BITS  = PROD_BITS - GAIN_FRAC;

   logic [PROD_BITS-1:0] prod_a;
   logic [PROD_BITS-1:0] prod_b;
   logic                 advance;

   logic                s1_valid_ff, s1_valid_in;
   logic [RAW_BITS-1:0] raw_a_ff, raw_a_in;
   logic [RAW_BITS-1:0] raw_b_ff, raw_b_in;
   logic                col_end_ff, col_end_in;

   function automatic level_type saturate(input logic [RAW_BITS-1:0] raw);
      return (raw > RAW_BITS'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX) : raw[LEVEL_BITS-1:0];
   endfunction

   assign prod_a = PROD_BITS'(req_mag_a) * PROD_BITS'(cfg.gain);
   assign prod_b = PROD_BITS'(req_mag_b) * PROD_BITS'(cfg.gain);

   // The stage moves on whenever it is empty or its word can enter the queue.
   assign advance   = !s1_valid_ff || !q_status.full;
   assign req_stall = s1_valid_ff && q_status.full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      raw_a_in    = raw_a_ff;
      raw_b_in    = raw_b_ff;
      col_end_in  = col_end_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         raw_a_in    = prod_a[PROD_BITS-1:GAIN_FRAC];
         raw_b_in    = prod_b[PROD_BITS-1:GAIN_FRAC];
         col_end_in  = req_column_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      raw_a_ff   <= raw_a_in;
      raw_b_ff   <= raw_b_in;
      col_end_ff <= col_end_in;
   end

   assign q_push                 = s1_valid_ff && !q_status.full;
   assign q_push_word.level_a    = saturate(raw_a_ff);
   assign q_push_word.level_b    = saturate(raw_b_ff);
   assign q_push_word.column_end = col_end_ff;

endmodule
`default_nettype wire

@@ src/wccm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wccm_queue
// Short first-in first-out queue of level words between front and back.
// ----------------------------------------------------------------------------
module wccm_queue
   import wccm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire queue_word_type push_word,
   input  wire logic           pop,
   output queue_word_type      pop_word,
   output queue_status_type    status
);

   queue_word_type store_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word     = store_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule
`default_nettype wire

@@ src/wccm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wccm_back
// Keeps the per-channel peaks and, at a column end, colors the pixel into
// the output register.
// ----------------------------------------------------------------------------
module wccm_back
   import wccm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   input  wire queue_word_type   q_pop_word,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COLOR_BITS-1:0] rsp_red,
   output logic [COLOR_BITS-1:0] rsp_green,
   output logic [COLOR_BITS-1:0] rsp_blue
);

   level_type peak_a_ff, peak_a_in;
   level_type peak_b_ff, peak_b_in;
   logic      valid_ff, valid_in;
   rgb_type   pixel_ff, pixel_in;

   level_type peak_a_next;
   level_type peak_b_next;
   level_type sum_level;
   rgb_type   col_a;
   rgb_type   col_b;
   rgb_type   pixel_calc;
   logic      out_free;

   assign out_free = !valid_ff || !rsp_stall;

   // Words that only update the peaks never wait for the output register.
   assign q_pop = !q_status.empty && (!q_pop_word.column_end || out_free);

   always_comb begin
      peak_a_next = (q_pop_word.level_a > peak_a_ff) ? q_pop_word.level_a : peak_a_ff;
      peak_b_next = peak_b_ff;
      if (!cfg.sum_mode && (q_pop_word.level_b > peak_b_ff)) begin
         peak_b_next = q_pop_word.level_b;
      end
      sum_level = (cfg.chan_a_on && cfg.chan_b_on) ? peak_a_next : '0;
      col_a     = first_colour(cfg.sum_mode ? sum_level : peak_a_next);
      col_b     = second_colour(peak_b_next);
      if (cfg.sum_mode) begin
         pixel_calc = col_a;
      end else begin
         pixel_calc.red   = sat_add(col_a.red, col_b.red);
         pixel_calc.green = sat_add(col_a.green, col_b.green);
         pixel_calc.blue  = sat_add(col_a.blue, col_b.blue);
      end
   end

   always_comb begin
      peak_a_in = peak_a_ff;
      peak_b_in = peak_b_ff;
      pixel_in  = pixel_ff;
      valid_in  = valid_ff && rsp_stall;
      if (q_pop) begin
         if (q_pop_word.column_end) begin
            peak_a_in = '0;
            peak_b_in = '0;
            pixel_in  = pixel_calc;
            valid_in  = 1'b1;
         end else begin
            peak_a_in = peak_a_next;
            peak_b_in = peak_b_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_a_ff <= '0;
         peak_b_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         peak_a_ff <= peak_a_in;
         peak_b_ff <= peak_b_in;
         valid_ff  <= valid_in;
      end
      pixel_ff <= pixel_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_red   = pixel_ff.red;
   assign rsp_green = pixel_ff.green;
   assign rsp_blue  = pixel_ff.blue;

endmodule
`default_nettype wire

@@ src/waterfall_column_colormap_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// waterfall_column_colormap_unit
// Colors one waterfall pixel per column of two-channel spectrum bins.
// ----------------------------------------------------------------------------
// The unit takes one bin word per clock, every clock, as long as the result
// side keeps up. A word passes a registered gain multiply stage, a four-word
// queue and the peak and palette stage; the last bin of a column passes the
// stage register and the queue before its pixel enters the output register.
// Bins that do not end a column keep flowing while a finished pixel waits to
// be taken; the input stalls only once the queue is full. The user must
// write configuration through the APB-style csr port only while no column
// is in flight; the block does not enforce this. Registers sit at byte
// addresses 0 (gain), 4 (sum mode), 8 (chan a enable), 12 (chan b enable).
module waterfall_column_colormap_unit
   import wccm_pkg::*;
#(
   parameter int MAG_BITS  = MAG_BITS_DEFAULT,
   parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [MAG_BITS-1:0]      req_mag_a,
   input  wire logic [MAG_BITS-1:0]      req_mag_b,
   input  wire logic                     req_column_end,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [COLOR_BITS-1:0]         rsp_red,
   output logic [COLOR_BITS-1:0]         rsp_green,
   output logic [COLOR_BITS-1:0]         rsp_blue,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   logic [1:0]       csr_index;
   queue_status_type q_status;
   queue_word_type   q_push_word;
   queue_word_type   q_pop_word;
   logic             q_push;
   logic             q_pop;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAIN:      cfg_in.gain      = csr_pwdata[GAIN_BITS-1:0];
            REG_SUM_MODE:  cfg_in.sum_mode  = csr_pwdata[0];
            REG_CHAN_A_ON: cfg_in.chan_a_on = csr_pwdata[0];
            REG_CHAN_B_ON: cfg_in.chan_b_on = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain      <= GAIN_BITS'(GAIN_RESET);
         cfg_ff.sum_mode  <= 1'b0;
         cfg_ff.chan_a_on <= 1'b1;
         cfg_ff.chan_b_on <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN:      csr_prdata = CSR_DATA_BITS'(cfg_ff.gain);
         REG_SUM_MODE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.sum_mode);
         REG_CHAN_A_ON: csr_prdata = CSR_DATA_BITS'(cfg_ff.chan_a_on);
         REG_CHAN_B_ON: csr_prdata = CSR_DATA_BITS'(cfg_ff.chan_b_on);
         default:       csr_prdata = '0;
      endcase
   end

   wccm_front #(
      .MAG_BITS  (MAG_BITS),
      .LEVEL_MAX (LEVEL_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mag_a      (req_mag_a),
      .req_mag_b      (req_mag_b),
      .req_column_end (req_column_end),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_push_word    (q_push_word)
   );

   wccm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .pop       (q_pop),
      .pop_word  (q_pop_word),
      .status    (q_status)
   );

   wccm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_pop_word (q_pop_word),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("queue pushed while full");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pixel_from_column_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop && q_pop_word.column_end))
      else $error("pixel produced without a column end word");

   a_stall_needs_full_queue: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_status.full)
      else $error("input stalled while the queue has room");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the waterfall column colormap unit. Spectrum bin
// words are streamed in phases under several register settings. A predictor
// tracks the per-channel peak levels and works out the pixel of each column.
// Every pixel word taken from the unit is compared against the oldest
// predicted pixel. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import wccm_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [MAG_BITS_DEFAULT-1:0] mag_a;
      logic [MAG_BITS_DEFAULT-1:0] mag_b;
      logic                        column_end;
      bit                          drain_first;
   } bin_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MAG_BITS_DEFAULT-1:0] req_mag_a = '0;
   logic [MAG_BITS_DEFAULT-1:0] req_mag_b = '0;
   logic                        req_column_end = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [COLOR_BITS-1:0]       rsp_red;
   logic [COLOR_BITS-1:0]       rsp_green;
   logic [COLOR_BITS-1:0]       rsp_blue;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]    csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]    csr_prdata;
   logic                        csr_pready;

   bin_word_type pending_bins[$];
   rgb_type      expected_pixels[$];
   bin_word_type cur_bin;
   cfg_type      colormap_cfg;
   level_type    peak_lvl_a;
   level_type    peak_lvl_b;
   int           mag_span = 1023;
   bit           steady = 1'b0;
   int           mismatches = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;

   waterfall_column_colormap_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mag_a      (req_mag_a),
      .req_mag_b      (req_mag_b),
      .req_column_end (req_column_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one; none in steady phases.
   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [MAG_BITS_DEFAULT-1:0] pick_mag();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? {MAG_BITS_DEFAULT{1'b1}} : {MAG_BITS_DEFAULT{1'b0}};
         1, 2: return MAG_BITS_DEFAULT'($urandom_range(0, 1023));
         3, 4: return MAG_BITS_DEFAULT'($urandom());
         default: return MAG_BITS_DEFAULT'($urandom_range(0, mag_span));
      endcase
   endfunction

   function automatic level_type scaled_level(input logic [MAG_BITS_DEFAULT-1:0] mag);
      logic [39:0] prod;
      prod = {24'd0, mag} * {16'd0, colormap_cfg.gain};
      prod = prod >> GAIN_FRAC;
      if (prod > LEVEL_MAX_DEFAULT) return level_type'(LEVEL_MAX_DEFAULT);
      return level_type'(prod);
   endfunction

   // Black to red to yellow to white.
   function automatic rgb_type heat_tint(input int v);
      rgb_type c;
      c = '0;
      if (v <= COLOR_MAX) begin
         c.red = color_type'(v);
      end else if (v <= RAMP_TWO) begin
         c.red   = color_type'(COLOR_MAX);
         c.green = color_type'(v - COLOR_MAX);
      end else begin
         c.red   = color_type'(COLOR_MAX);
         c.green = color_type'(COLOR_MAX);
         c.blue  = color_type'(v - RAMP_TWO);
      end
      return c;
   endfunction

   // Black to green to blue to white.
   function automatic rgb_type cool_tint(input int v);
      rgb_type c;
      c = '0;
      if (v <= COLOR_MAX) begin
         c.green = color_type'(v);
      end else if (v <= RAMP_TWO) begin
         c.green = color_type'(RAMP_TWO - v);
         c.blue  = color_type'(v - COLOR_MAX);
      end else begin
         c.red   = color_type'(v - RAMP_TWO);
         c.green = color_type'(v - RAMP_TWO);
         c.blue  = color_type'(COLOR_MAX);
      end
      return c;
   endfunction

   function automatic color_type clip_sum(input color_type x, input color_type y);
      int s;
      s = int'(x) + int'(y);
      return (s > COLOR_MAX) ? color_type'(COLOR_MAX) : color_type'(s);
   endfunction

   // Folds one accepted bin into the peaks and queues the pixel at a column end.
   task automatic absorb_bin(input bin_word_type w);
      level_type lvl;
      rgb_type   warm;
      rgb_type   cool;
      rgb_type   pix;
      lvl = scaled_level(w.mag_a);
      if (lvl > peak_lvl_a) peak_lvl_a = lvl;
      if (!colormap_cfg.sum_mode) begin
         lvl = scaled_level(w.mag_b);
         if (lvl > peak_lvl_b) peak_lvl_b = lvl;
      end
      if (w.column_end) begin
         if (colormap_cfg.sum_mode) begin
            // A disabled channel blanks the summed spectrum.
            pix = heat_tint((colormap_cfg.chan_a_on && colormap_cfg.chan_b_on) ?
                            int'(peak_lvl_a) : 0);
         end else begin
            warm = heat_tint(int'(peak_lvl_a));
            cool = cool_tint(int'(peak_lvl_b));
            pix.red   = clip_sum(warm.red, cool.red);
            pix.green = clip_sum(warm.green, cool.green);
            pix.blue  = clip_sum(warm.blue, cool.blue);
         end
         expected_pixels.push_back(pix);
         peak_lvl_a = '0;
         peak_lvl_b = '0;
      end
   endtask

   task automatic report_pixel(input string what, input rgb_type want, input rgb_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $time, what,
                  want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes all four registers; unused upper data bits carry junk at times.
   task automatic set_config(input logic [GAIN_BITS-1:0] gain_val, input bit sum_val,
                             input bit a_val, input bit b_val);
      logic [CSR_DATA_BITS-1:0] junk;
      longint                   span;
      junk = $urandom_range(0, 1) ? $urandom() : '0;
      csr_write(REG_GAIN, {junk[CSR_DATA_BITS-1:GAIN_BITS], gain_val});
      csr_write(REG_SUM_MODE, {junk[CSR_DATA_BITS-1:1], sum_val});
      csr_write(REG_CHAN_A_ON, {junk[CSR_DATA_BITS-1:1], a_val});
      csr_write(REG_CHAN_B_ON, {junk[CSR_DATA_BITS-1:1], b_val});
      colormap_cfg.gain      = gain_val;
      colormap_cfg.sum_mode  = sum_val;
      colormap_cfg.chan_a_on = a_val;
      colormap_cfg.chan_b_on = b_val;
      // Pick magnitudes mostly in the range that maps onto the palettes.
      span = (gain_val == 0) ? 65535 : (longint'(800) * 65536) / longint'(gain_val);
      if (span > 65535) span = 65535;
      if (span < 1) span = 1;
      mag_span = int'(span);
   endtask

   task automatic add_bin(input logic [MAG_BITS_DEFAULT-1:0] a,
                          input logic [MAG_BITS_DEFAULT-1:0] b,
                          input logic col_end, input bit drain = 1'b0);
      bin_word_type w;
      w.mag_a       = a;
      w.mag_b       = b;
      w.column_end  = col_end;
      w.drain_first = drain;
      pending_bins.push_back(w);
   endtask

   task automatic load_random(input int count, input int end_pct);
      for (int i = 0; i < count; i++) begin
         add_bin(pick_mag(), pick_mag(),
                 (i == count - 1) || ($urandom_range(0, 99) < end_pct),
                 $urandom_range(0, 49) == 0);
      end
   endtask

   // Waits until every bin is in and every pixel is out, then lets the pipe drain.
   task automatic settle();
      while (pending_bins.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : bin_driver
      logic launch;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_bin(cur_bin);
         end
         if (!req_valid || !req_stall) begin
            launch = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bins.size() != 0) begin
               // A flagged word holds off until all earlier pixels are back.
               launch = !(pending_bins[0].drain_first && expected_pixels.size() != 0);
            end
            if (launch) begin
               cur_bin = pending_bins.pop_front();
               req_mag_a      <= cur_bin.mag_a;
               req_mag_b      <= cur_bin.mag_b;
               req_column_end <= cur_bin.column_end;
               gap_left = pick_pause();
            end
            req_valid <= launch;
         end
      end
   end

   always @(posedge clock) begin : pixel_monitor
      rgb_type want;
      rgb_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_red, rsp_green, rsp_blue};
            if (expected_pixels.size() == 0) begin
               report_pixel("pixel word with no column pending", '0, got);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red !== want.red || rsp_green !== want.green ||
                   rsp_blue !== want.blue) begin
                  report_pixel("pixel mismatch", want, got);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_pause();
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [GAIN_BITS-1:0] g;
      colormap_cfg.gain      = GAIN_BITS'(GAIN_RESET);
      colormap_cfg.sum_mode  = 1'b0;
      colormap_cfg.chan_a_on = 1'b1;
      colormap_cfg.chan_b_on = 1'b1;
      peak_lvl_a = '0;
      peak_lvl_b = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, unit gain: palette corners, saturation and peak holding.
      add_bin(0, 0, 1);
      add_bin(255, 0, 1);
      add_bin(0, 255, 1);
      add_bin(256, 0, 1);
      add_bin(0, 300, 1);
      add_bin(510, 510, 1);
      add_bin(511, 511, 1);
      add_bin(0, 764, 1);
      add_bin(16'hFFFF, 16'hFFFF, 1);
      add_bin(200, 200, 1);
      add_bin(400, 100, 1);
      add_bin(400, 200, 1);
      add_bin(100, 700, 0);
      add_bin(700, 100, 0);
      add_bin(50, 50, 1);
      add_bin(300, 0, 0);
      add_bin(0, 0, 1, 1'b1);
      load_random(50, 30);
      settle();

      steady = 1'b1;
      set_config('0, 1'b0, 1'b1, 1'b1);
      load_random(20, 30);
      settle();
      steady = 1'b0;

      set_config({GAIN_BITS{1'b1}}, 1'b0, 1'b1, 1'b1);
      load_random(30, 25);
      settle();

      set_config(GAIN_BITS'(1), 1'b0, 1'b1, 1'b1);
      load_random(15, 50);
      settle();

      set_config(GAIN_BITS'($urandom_range(256, 4096)), 1'b0, 1'b1, 1'b1);
      load_random(50, 20);
      settle();

      // Summed spectrum: channel b input must have no effect.
      set_config(GAIN_BITS'(GAIN_RESET), 1'b1, 1'b1, 1'b1);
      add_bin(0, 16'hFFFF, 1);
      add_bin(300, 0, 1);
      add_bin(600, 0, 0);
      add_bin(50, 999, 1);
      add_bin(16'hFFFF, 0, 1);
      add_bin(255, 16'hFFFF, 1);
      load_random(50, 30);
      settle();

      set_config(GAIN_BITS'($urandom_range(4096, 131072)), 1'b1, 1'b0, 1'b1);
      load_random(25, 30);
      settle();

      set_config(GAIN_BITS'(GAIN_RESET), 1'b1, 1'b1, 1'b0);
      load_random(25, 30);
      settle();

      set_config(GAIN_BITS'(GAIN_RESET), 1'b1, 1'b0, 1'b0);
      load_random(15, 40);
      settle();

      // Channel enables are don't-care outside sum mode.
      set_config(GAIN_BITS'($urandom_range(8192, 98304)), 1'b0, 1'b0, 1'b0);
      load_random(35, 25);
      settle();

      repeat (4) begin
         case ($urandom_range(0, 5))
            0: g = '0;
            1: g = GAIN_BITS'(1);
            2: g = GAIN_BITS'(GAIN_RESET);
            3: g = {GAIN_BITS{1'b1}};
            4: g = GAIN_BITS'($urandom());
            default: g = GAIN_BITS'($urandom_range(200, 200000));
         endcase
         steady = ($urandom_range(0, 2) == 0);
         set_config(g, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         load_random(30, $urandom_range(10, 100));
         settle();
      end

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
